@@ hw/rtl/btha_pkg.sv @@
// Package for the block table heap allocator: request and response payloads,
// table entry layout, table port structs and status codes.
// Has no dependencies; every other file of the block imports it.
package btha_pkg;

    // Number of block descriptors in the table.
    localparam int ENTRIES = 16;
    // Table index width, and counter width that can also hold ENTRIES.
    localparam int TBL_IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TBL_CW = $clog2(ENTRIES + 1);

    // Size mark of a descriptor that has never been used.
    localparam logic [15:0] FRESH_SIZE = 16'hBEEF;
    // Bump pointer value after reset.
    localparam logic [31:0] HEAP_BASE_RESET = 32'h0010_0000;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FRESH  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    // Request payload.
    typedef struct packed {
        logic        operation;
        logic [15:0] request_size;
        logic [31:0] address;
    } t_req;

    // Response payload.
    typedef struct packed {
        logic [31:0] block_address;
        t_status     status;
    } t_rsp;

    // One block descriptor as stored in the table.
    typedef struct packed {
        logic        used;
        logic [15:0] size;
        logic [31:0] start;
    } t_entry;

    // Table read port.
    typedef struct packed {
        logic              en;
        logic [TBL_IW-1:0] addr;
    } t_tbl_rd;

    // Table write port.
    typedef struct packed {
        logic              en;
        logic [TBL_IW-1:0] addr;
        t_entry            data;
    } t_tbl_wr;

endpackage

@@ hw/rtl/btha_table.sv @@
// Descriptor table: one synchronous memory with one write and one read port,
// registered read, plus per-entry valid bits. Depends on btha_pkg.
// An entry that was never written reads as the reset descriptor.
module btha_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  btha_pkg::t_tbl_wr i_wr,
    input  btha_pkg::t_tbl_rd i_rd,
    output btha_pkg::t_entry  o_rd_data
);
    import btha_pkg::*;

    t_entry               r_mem [ENTRIES];
    logic [ENTRIES-1:0]   r_valid;
    t_entry               r_rd_data;
    logic                 r_rd_valid;
    t_entry               reset_entry;

    assign reset_entry = '{used: 1'b0, size: FRESH_SIZE, start: '0};

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    // Valid bits are cleared together by reset and set by the first write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_valid <= r_valid[i_rd.addr];
            end
        end
    end

    // Entries never written show the reset descriptor.
    assign o_rd_data = r_rd_valid ? r_rd_data : reset_entry;

endmodule

@@ hw/rtl/btha_ctrl.sv @@
// Allocator sequencer: scans the descriptor table one entry per cycle, picks
// the matching, first-fit or fresh descriptor, writes it back and drives the
// response register. Holds the bump pointer. Depends on btha_pkg.
module btha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  btha_pkg::t_req    i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output btha_pkg::t_rsp    o_rsp,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    output btha_pkg::t_tbl_rd o_rd,
    output btha_pkg::t_tbl_wr o_wr,
    input  btha_pkg::t_entry  i_rd_data
);
    import btha_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_PUSH
    } t_state;

    // Control state.
    t_state            r_state,     n_state;
    logic [TBL_CW-1:0] r_issue,     n_issue;
    logic              r_chk_live,  n_chk_live;
    logic              r_hit,       n_hit;
    logic              r_fresh,     n_fresh;
    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_bump,      n_bump;

    // Payload state.
    t_req              r_req,       n_req;
    logic [TBL_IW-1:0] r_chk_idx,   n_chk_idx;
    logic [TBL_IW-1:0] r_hit_idx,   n_hit_idx;
    logic [TBL_IW-1:0] r_fresh_idx, n_fresh_idx;
    t_entry            r_hit_entry, n_hit_entry;
    t_rsp              r_res,       n_res;
    t_rsp              r_out,       n_out;

    logic              out_free;
    logic [32:0]       bump_end;
    t_tbl_rd           rd;
    t_tbl_wr           wr;

    assign out_free = !r_out_valid || i_rsp_ready;
    assign bump_end = {1'b0, r_bump} + {17'b0, r_req.request_size};

    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_hit       = r_hit;
        n_fresh     = r_fresh;
        n_out_valid = r_out_valid;
        n_bump      = r_bump;
        n_req       = r_req;
        n_hit_idx   = r_hit_idx;
        n_fresh_idx = r_fresh_idx;
        n_hit_entry = r_hit_entry;
        n_res       = r_res;
        n_out       = r_out;
        rd          = '0;
        wr          = '0;

        case (r_state)
            // Take a request and start the table scan.
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_issue = '0;
                    n_hit   = 1'b0;
                    n_fresh = 1'b0;
                    n_state = S_SCAN;
                end
            end

            // Issue one read per cycle and check the entry whose read was issued in the previous cycle.
            S_SCAN: begin
                if (r_issue < TBL_CW'(ENTRIES)) begin
                    rd.en   = 1'b1;
                    rd.addr = r_issue[TBL_IW-1:0];
                    n_issue = r_issue + TBL_CW'(1);
                end
                if (r_chk_live) begin
                    if (r_req.operation == OP_FREE) begin
                        if (!r_hit && i_rd_data.start == r_req.address) begin
                            n_hit       = 1'b1;
                            n_hit_idx   = r_chk_idx;
                            n_hit_entry = i_rd_data;
                        end
                    end else begin
                        if (!r_hit && !i_rd_data.used && i_rd_data.start != '0 &&
                            i_rd_data.size >= r_req.request_size) begin
                            n_hit       = 1'b1;
                            n_hit_idx   = r_chk_idx;
                            n_hit_entry = i_rd_data;
                        end
                        if (!r_fresh && !i_rd_data.used && i_rd_data.start == '0 &&
                            i_rd_data.size == FRESH_SIZE) begin
                            n_fresh     = 1'b1;
                            n_fresh_idx = r_chk_idx;
                        end
                    end
                    if (r_chk_idx == TBL_IW'(ENTRIES - 1)) begin
                        n_state = S_RESOLVE;
                    end
                end
            end

            // Decide the outcome and write the chosen descriptor back, if any.
            S_RESOLVE: begin
                n_res   = '{block_address: '0, status: ST_OK};
                n_state = S_PUSH;
                if (r_req.operation == OP_FREE) begin
                    if (r_hit) begin
                        wr.en        = 1'b1;
                        wr.addr      = r_hit_idx;
                        wr.data      = r_hit_entry;
                        wr.data.used = 1'b0;
                    end else begin
                        n_res.status = ST_NOT_FOUND;
                    end
                end else if (r_hit) begin
                    wr.en               = 1'b1;
                    wr.addr             = r_hit_idx;
                    wr.data             = '{used: 1'b1, size: r_req.request_size,
                                            start: r_hit_entry.start};
                    n_res.block_address = r_hit_entry.start;
                end else if (!r_fresh) begin
                    n_res.status = ST_NO_FRESH;
                end else if (bump_end[32]) begin
                    n_res.status = ST_OVERFLOW;
                end else begin
                    wr.en               = 1'b1;
                    wr.addr             = r_fresh_idx;
                    wr.data             = '{used: 1'b1, size: r_req.request_size,
                                            start: r_bump};
                    n_res.block_address = r_bump;
                    n_bump              = bump_end[31:0];
                end
            end

            // Hand the result to the response register once it is free.
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Response register.
        if (r_state == S_PUSH && out_free) begin
            n_out_valid = 1'b1;
            n_out       = r_res;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end

        // A heap base write reloads the bump pointer.
        if (i_cfg_we) begin
            n_bump = i_cfg_wdata;
        end

        n_chk_live = rd.en;
        n_chk_idx  = rd.addr;
    end

    // Control state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= '0;
            r_chk_live  <= 1'b0;
            r_hit       <= 1'b0;
            r_fresh     <= 1'b0;
            r_out_valid <= 1'b0;
            r_bump      <= HEAP_BASE_RESET;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_chk_live  <= n_chk_live;
            r_hit       <= n_hit;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
            r_bump      <= n_bump;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_chk_idx   <= n_chk_idx;
        r_hit_idx   <= n_hit_idx;
        r_fresh_idx <= n_fresh_idx;
        r_hit_entry <= n_hit_entry;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;
    assign o_rd        = rd;
    assign o_wr        = wr;

endmodule

@@ hw/rtl/block_table_heap_allocator.sv @@
// Top level of the block table heap allocator: sequencer plus descriptor table.
// Depends on btha_pkg, btha_table and btha_ctrl.
//
//   Channel   Direction  Handshake                     Payload
//   request   in         i_req_valid / o_req_ready     i_req (t_req)
//   response  out        o_rsp_valid / i_rsp_ready     o_rsp (t_rsp)
//   config    in         i_cfg_we (no wait)            i_cfg_wdata (heap base)
//
// Each request runs a full table scan through the single read port; a new
// request is taken only once the last result is in the response register.
// Reset clears the valid bits of the table at once, so no clearing pass runs.
// A stalled response is held in the output register; a new request is taken
// while it waits, and that request's result waits in the sequencer until the
// register frees up.
module block_table_heap_allocator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  btha_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output btha_pkg::t_rsp o_rsp,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_wdata
);
    import btha_pkg::*;

    t_tbl_rd tbl_rd;
    t_tbl_wr tbl_wr;
    t_entry  tbl_rd_data;

    // Sequencer with bump pointer and response register.
    btha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rd        (tbl_rd),
        .o_wr        (tbl_wr),
        .i_rd_data   (tbl_rd_data)
    );

    // Descriptor table memory.
    btha_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd      (tbl_rd),
        .o_rd_data (tbl_rd_data)
    );

endmodule

@@ hw/rtl/btha_checker.sv @@
// Port-level checker for the block table heap allocator, bound to the top.
// Depends on btha_pkg and block_table_heap_allocator.
module btha_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_ready,
    input logic           o_rsp_valid,
    input logic           i_rsp_ready,
    input btha_pkg::t_rsp o_rsp
);
    import btha_pkg::*;

    // A response not taken stays valid with the same payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    // Every error status carries a zero block address.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_OK |-> o_rsp.block_address == '0)
        else $error("error response with nonzero address");

    // An accepted request keeps the sequencer busy for the next cycle.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken back to back");

    // No response can come out of reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid right after reset");

endmodule

bind block_table_heap_allocator btha_checker u_btha_checker (.*);

@@ bench/tb_block_table_heap_allocator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the block table heap allocator: directed and random
// allocate/free requests, checked against an in-bench model of the descriptor table.
// Depends on btha_pkg and the block_table_heap_allocator RTL.
module tb_block_table_heap_allocator;
    import btha_pkg::*;

    localparam int RAND_PHASES      = 12;
    localparam int ITEMS_PER_PHASE  = 108;
    localparam int BACKLOG_DEPTH    = 3;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int POOL_CAP         = 48;
    localparam int SETTLE_CYCLES    = 2 * ENTRIES + 8;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_req_valid = 1'b0;
    t_req           i_req       = '0;
    logic           i_rsp_ready = 1'b0;
    logic           i_cfg_we    = 1'b0;
    logic [31:0]    i_cfg_wdata = '0;
    logic           o_req_ready;
    logic           o_rsp_valid;
    t_rsp           o_rsp;

    block_table_heap_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the descriptor table and the bump pointer.
    logic [31:0] blk_start [ENTRIES];
    logic [15:0] blk_size  [ENTRIES];
    logic        blk_used  [ENTRIES];
    logic [31:0] bump_ptr;
    logic [31:0] heap_base_q;

    t_req        req_backlog [$];
    t_rsp        rsp_awaited [$];
    logic [31:0] live_blocks [$];

    bit req_taken  = 1'b0;
    bit rsp_taken  = 1'b0;
    bit drv_busy   = 1'b0;
    bit calm_phase = 1'b0;
    bit hold_done  = 1'b0;
    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    int rsp_count  = 0;
    int mismatches = 0;
    t_req cur_req  = '0;

    // Applies one request to the shadow table and returns the response it must give.
    function automatic t_rsp apply_heap_request(t_req r);
        t_rsp        rsp;
        logic [32:0] end_addr;
        bit          done;
        rsp.block_address = '0;
        rsp.status        = ST_OK;
        done              = 1'b0;
        if (r.operation == OP_FREE) begin
            rsp.status = ST_NOT_FOUND;
            for (int i = 0; i < ENTRIES && !done; i++) begin
                if (blk_start[i] == r.address) begin
                    blk_used[i] = 1'b0;
                    rsp.status  = ST_OK;
                    done        = 1'b1;
                end
            end
            return rsp;
        end
        // First fit over released blocks.
        for (int i = 0; i < ENTRIES && !done; i++) begin
            if (!blk_used[i] && blk_start[i] != 32'd0 && blk_size[i] >= r.request_size) begin
                blk_size[i]       = r.request_size;
                blk_used[i]       = 1'b1;
                rsp.block_address = blk_start[i];
                done              = 1'b1;
            end
        end
        // Otherwise claim the lowest never-used descriptor at the bump pointer.
        for (int i = 0; i < ENTRIES && !done; i++) begin
            if (!blk_used[i] && blk_start[i] == 32'd0 && blk_size[i] == FRESH_SIZE) begin
                end_addr = {1'b0, bump_ptr} + {17'd0, r.request_size};
                done     = 1'b1;
                if (end_addr > 33'h0_FFFF_FFFF) begin
                    rsp.status = ST_OVERFLOW;
                end else begin
                    blk_start[i]      = bump_ptr;
                    blk_size[i]       = r.request_size;
                    blk_used[i]       = 1'b1;
                    rsp.block_address = bump_ptr;
                    bump_ptr          = end_addr[31:0];
                end
            end
        end
        if (!done) begin
            rsp.status = ST_NO_FRESH;
        end
        return rsp;
    endfunction

    // Monitor: tracks handshakes, updates the model and checks responses.
    always @(posedge i_clk) begin
        t_rsp want;
        req_taken = 1'b0;
        rsp_taken = 1'b0;
        if (!i_rst_n) begin
            heap_base_q = HEAP_BASE_RESET;
            bump_ptr    = HEAP_BASE_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                blk_start[i] = '0;
                blk_size[i]  = FRESH_SIZE;
                blk_used[i]  = 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                heap_base_q = i_cfg_wdata;
                bump_ptr    = i_cfg_wdata;
            end
            if (i_req_valid && o_req_ready) begin
                req_taken = 1'b1;
                want = apply_heap_request(i_req);
                rsp_awaited.push_back(want);
                if (i_req.operation == OP_ALLOC && want.status == ST_OK) begin
                    if (live_blocks.size() >= POOL_CAP) begin
                        void'(live_blocks.pop_front());
                    end
                    live_blocks.push_back(want.block_address);
                end
            end
            if (o_rsp_valid && i_rsp_ready) begin
                rsp_taken = 1'b1;
                rsp_count++;
                if (rsp_awaited.size() == 0) begin
                    $display("%0t: unexpected response: expected none, actual addr %h status %0d",
                             $time, o_rsp.block_address, o_rsp.status);
                    mismatches++;
                end else begin
                    want = rsp_awaited.pop_front();
                    if (o_rsp.block_address !== want.block_address) begin
                        $display("%0t: block_address mismatch: expected %h, actual %h",
                                 $time, want.block_address, o_rsp.block_address);
                        mismatches++;
                    end
                    if (o_rsp.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, o_rsp.status);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Request driver: holds each request until accepted, then idles a random gap.
    always @(negedge i_clk) begin
        if (drv_busy && req_taken) begin
            drv_busy = 1'b0;
        end
        if (!drv_busy) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (req_backlog.size() > 0) begin
                cur_req  = req_backlog.pop_front();
                drv_busy = 1'b1;
                gap_left = calm_phase ? 0 : $urandom_range(0, 4);
            end
        end
        i_req_valid <= drv_busy;
        i_req       <= cur_req;
    end

    // Response side: random stall after every response, plus one long hold-off.
    always @(negedge i_clk) begin
        logic rdy;
        if (rsp_taken) begin
            stall_left = calm_phase ? 0 : $urandom_range(0, 4);
        end
        if (!hold_done && rsp_count >= LONG_HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        i_rsp_ready <= rdy;
    end

    // Waits until the backlog has room for another request.
    task automatic await_room();
        while (req_backlog.size() >= BACKLOG_DEPTH) begin
            @(negedge i_clk);
        end
    endtask

    task automatic queue_req(input logic op, input logic [15:0] size, input logic [31:0] addr);
        t_req r;
        r.operation    = op;
        r.request_size = size;
        r.address      = addr;
        await_room();
        req_backlog.push_back(r);
    endtask

    // Waits until every request has been accepted and answered.
    task automatic drain();
        while (req_backlog.size() != 0 || drv_busy || rsp_awaited.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_heap_base(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stimulus: directed corner cases, then random phases over several heap bases.
    initial begin
        t_req        r;
        int          roll;
        int          pick;
        int          k;
        logic [31:0] base;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero-size and extreme sizes, free on a start shared by two blocks,
        // reuse of a zero-size block, a free miss, free of address zero.
        queue_req(OP_ALLOC, 16'd0, '0);
        queue_req(OP_ALLOC, 16'hFFFF, '0);
        queue_req(OP_ALLOC, FRESH_SIZE, '0);
        queue_req(OP_FREE, 16'd0, HEAP_BASE_RESET);
        queue_req(OP_ALLOC, 16'd0, '0);
        queue_req(OP_FREE, 16'hFFFF, 32'hDEAD_BEEF);
        queue_req(OP_FREE, 16'd0, 32'd0);
        drain();

        // Fresh block placed at address zero, then freed again.
        set_heap_base(32'd0);
        queue_req(OP_ALLOC, FRESH_SIZE, '0);
        queue_req(OP_FREE, 16'd0, 32'd0);
        drain();

        // Bump pointer overflow around the top of the address space.
        set_heap_base(32'hFFFF_FFF0);
        queue_req(OP_ALLOC, 16'h0011, '0);
        queue_req(OP_ALLOC, 16'h000F, '0);
        queue_req(OP_ALLOC, 16'd0, '0);
        queue_req(OP_ALLOC, 16'd1, '0);
        drain();

        // Use up every remaining descriptor.
        set_heap_base(32'h0000_1000);
        for (int i = 0; i < 11; i++) begin
            queue_req(OP_ALLOC, 16'hFFFF, '0);
        end
        drain();

        // Full table takes precedence over an overflow.
        set_heap_base(32'hFFFF_FFFF);
        queue_req(OP_ALLOC, 16'hFFFF, '0);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                1, 5, 8, 11: base = 32'd0;
                2:           base = 32'hFFFF_FFFF;
                3:           base = HEAP_BASE_RESET;
                4:           base = 32'hFFFF_0000;
                7:           base = 32'h8000_0000;
                9:           base = 32'hFFFF_FF00;
                default:     base = $urandom();
            endcase
            set_heap_base(base);
            calm_phase = (ph == 3 || ph == 8);
            // With the pointer at zero, recycle one descriptor as never-used.
            if (base == 32'd0) begin
                queue_req(OP_ALLOC, FRESH_SIZE, '0);
                queue_req(OP_FREE, 16'd0, 32'd0);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                await_room();
                r.request_size = 16'($urandom());
                r.address      = $urandom();
                roll           = $urandom_range(0, 99);
                if (roll < 48) begin
                    r.operation = OP_ALLOC;
                    pick = $urandom_range(0, 19);
                    case (pick)
                        0:       r.request_size = 16'd0;
                        1:       r.request_size = 16'hFFFF;
                        2:       r.request_size = FRESH_SIZE;
                        3, 4:    r.request_size = 16'($urandom());
                        5, 6, 7: r.request_size = 16'($urandom_range(0, 16'h0FFF));
                        default: r.request_size = 16'($urandom_range(1, 63));
                    endcase
                end else if (roll < 88 && live_blocks.size() > 0) begin
                    // Well-formed free of a block handed out earlier.
                    r.operation = OP_FREE;
                    k = $urandom_range(0, live_blocks.size() - 1);
                    r.address = live_blocks[k];
                    live_blocks.delete(k);
                end else begin
                    r.operation = OP_FREE;
                    pick = $urandom_range(0, 2);
                    if (pick == 0) begin
                        r.address = 32'd0;
                    end else if (pick == 1) begin
                        r.address = heap_base_q + $urandom_range(0, 64);
                    end
                end
                req_backlog.push_back(r);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (rsp_awaited.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, rsp_awaited.size());
        end
        if (mismatches == 0 && rsp_awaited.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ block_table_heap_allocator.f @@
hw/rtl/btha_pkg.sv
hw/rtl/btha_table.sv
hw/rtl/btha_ctrl.sv
hw/rtl/block_table_heap_allocator.sv
hw/rtl/btha_checker.sv
bench/tb_block_table_heap_allocator.sv
